// File: rtl/otsu_threshold_binarizer_macros.svh
// assertion macros for the otsu threshold binarizer
// no dependencies; included by modules that carry concurrent checks
`ifndef OTSU_THRESHOLD_BINARIZER_MACROS_SVH
`define OTSU_THRESHOLD_BINARIZER_MACROS_SVH
`ifndef SYNTHESIS
`define OTB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");
`define OTB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define OTB_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define OTB_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/otb_pkg.sv
// shared types and constants for the otsu threshold binarizer
// no dependencies
package otb_pkg;

    localparam int BINS_DEF       = 256;
    localparam int MAX_PIXELS_DEF = 1048576;

    localparam logic CMD_ACCUM    = 1'b0;
    localparam logic CMD_BINARIZE = 1'b1;
    localparam logic KIND_REPORT  = 1'b0;
    localparam logic KIND_MASK    = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_SR_RD,
        ST_SR_ACC,
        ST_SR_CHK,
        ST_MUL,
        ST_NEXT,
        ST_FIN,
        ST_OUT
    } state_t;

    // which product the shared multiplier is working on
    typedef enum logic [2:0] {
        OP_A,
        OP_B,
        OP_P,
        OP_D2,
        OP_L,
        OP_E2,
        OP_R
    } op_t;

endpackage

// File: rtl/otsu_threshold_binarizer.sv
// otsu threshold binarizer top level: histogram, threshold search, binarize
// depends on otb_pkg and otsu_threshold_binarizer_macros.svh
//
// Pixels arrive as transactions on the s_ side: tuser is the command (0 accumulate,
// 1 binarize), tdata[7:0] the pixel, tlast marks the final accumulated pixel.
// An accumulate transaction reads, increments and writes back one histogram
// bin in the memory. A binarize transaction returns its mask in the cycle
// after it is accepted. An accumulate marked last starts the threshold
// search: every bin is visited in turn and every split with two nonempty classes
// is scored with one shared shift-add multiplier that forms up to seven products
// per split, one multiplier bit per cycle. The histogram is then cleared at once
// through per-bin valid bits and the threshold report goes out as a transaction
// with tuser 0. s_tready stays low while any of this work runs.
`include "otsu_threshold_binarizer_macros.svh"

module otsu_threshold_binarizer
    import otb_pkg::*;
#(
    parameter int BINS       = BINS_DEF,
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    input  logic        s_tuser,   // [0] command
    input  logic        s_tlast,   // last pixel of the accumulate pass
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] threshold, [8] mask, rest zero
    output logic        m_tuser    // [0] kind
);

    localparam int BW = (BINS > 1) ? $clog2(BINS) : 1;  // bin index width
    localparam int CW = $clog2(MAX_PIXELS + 1);          // pixel count width
    localparam int IW = CW + 8;                          // intensity sum width
    localparam int DW = IW + CW;                         // s*n product width
    localparam int QW = 2 * CW;                          // n0*n1 width
    localparam int PW = 2 * DW + QW;                     // widest product

    // control state
    state_t          state_reg, state_next;
    op_t             op_reg, op_next;
    logic [BINS-1:0] hvalid_reg, hvalid_next;
    logic [CW-1:0]   ptot_reg, ptot_next;
    logic [IW-1:0]   itot_reg, itot_next;
    logic [7:0]      chosen_reg, chosen_next;
    logic            m_valid_reg, m_valid_next;
    logic [BW-1:0]   t_reg, t_next;
    logic            have_reg, have_next;

    // payload and datapath registers
    logic [BW-1:0]   bin_reg, bin_next;
    logic            count_reg, count_next;
    logic            last_reg, last_next;
    logic [7:0]      m_thr_reg, m_thr_next;
    logic            m_mask_reg, m_mask_next;
    logic            m_kind_reg, m_kind_next;
    logic [CW-1:0]   n0_reg, n0_next, n1_reg, n1_next;
    logic [IW-1:0]   s0_reg, s0_next, s1_reg, s1_next;
    logic [DW-1:0]   a_reg, a_next, d_reg, d_next, best_d_reg, best_d_next;
    logic [QW-1:0]   p_reg, p_next, best_p_reg, best_p_next;
    logic [7:0]      best_t_reg, best_t_next;
    logic [PW-1:0]   lhs_reg, lhs_next;

    // shared shift-add multiplier
    logic [PW-1:0]   mcand_reg, mcand_next, acc_reg, acc_next;
    logic [DW-1:0]   mplier_reg, mplier_next;

    // histogram memory
    logic [CW-1:0]   hist_mem [BINS];
    logic [CW-1:0]   rd_data_reg;
    logic [BW-1:0]   rd_addr;
    logic            mem_we;
    logic [CW-1:0]   mem_wdata;
    logic [CW-1:0]   hval;

    logic            s_fire, out_free;
    logic [BW-1:0]   pix_bin;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_fire   = s_tvalid && s_tready;

    // pixels above the top bin fold into it
    assign pix_bin = ({1'b0, s_tdata} > 9'(BINS - 1)) ? BW'(BINS - 1) : BW'(s_tdata);

    // the search keeps its bin address while the read data is consumed
    assign rd_addr = (state_reg == ST_SR_RD || state_reg == ST_SR_ACC) ? t_reg : bin_reg;
    // a bin not written since the last clear reads as zero
    assign hval = hvalid_reg[rd_addr] ? rd_data_reg : '0;

    always_ff @(posedge aclk) begin
        rd_data_reg <= hist_mem[rd_addr];
        if (mem_we) begin
            hist_mem[bin_reg] <= mem_wdata;
        end
    end

    // widen a value to the product width of the shared unit
    function automatic logic [PW-1:0] ext_p(input logic [DW-1:0] v);
        ext_p = PW'(v);
    endfunction

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        hvalid_next  = hvalid_reg;
        ptot_next    = ptot_reg;
        itot_next    = itot_reg;
        chosen_next  = chosen_reg;
        m_valid_next = m_valid_reg;
        t_next       = t_reg;
        have_next    = have_reg;
        bin_next     = bin_reg;
        count_next   = count_reg;
        last_next    = last_reg;
        m_thr_next   = m_thr_reg;
        m_mask_next  = m_mask_reg;
        m_kind_next  = m_kind_reg;
        n0_next      = n0_reg;
        n1_next      = n1_reg;
        s0_next      = s0_reg;
        s1_next      = s1_reg;
        a_next       = a_reg;
        d_next       = d_reg;
        best_d_next  = best_d_reg;
        p_next       = p_reg;
        best_p_next  = best_p_reg;
        best_t_next  = best_t_reg;
        lhs_next     = lhs_reg;
        mcand_next   = mcand_reg;
        acc_next     = acc_reg;
        mplier_next  = mplier_reg;
        mem_we       = 1'b0;
        mem_wdata    = hval + CW'(1);

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_tuser == CMD_BINARIZE) begin
                        m_valid_next = 1'b1;
                        m_kind_next  = KIND_MASK;
                        m_thr_next   = chosen_reg;
                        m_mask_next  = (s_tdata >= chosen_reg);
                    end else begin
                        bin_next   = pix_bin;
                        count_next = (ptot_reg < CW'(MAX_PIXELS));
                        last_next  = s_tlast;
                        state_next = ST_ACC_RD;
                    end
                end
            end
            ST_ACC_RD: begin
                state_next = ST_ACC_WR;
            end
            ST_ACC_WR: begin
                if (count_reg) begin
                    mem_we               = 1'b1;
                    hvalid_next[bin_reg] = 1'b1;
                    ptot_next            = ptot_reg + CW'(1);
                    itot_next            = itot_reg + IW'(bin_reg);
                end
                if (last_reg) begin
                    t_next     = '0;
                    have_next  = 1'b0;
                    n0_next    = '0;
                    s0_next    = '0;
                    best_t_next = '0;
                    state_next = ST_SR_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SR_RD: begin
                state_next = ST_SR_ACC;
            end
            ST_SR_ACC: begin
                n0_next    = n0_reg + hval;
                s0_next    = s0_reg + IW'(hval) * IW'(t_reg);
                state_next = ST_SR_CHK;
            end
            ST_SR_CHK: begin
                n1_next = ptot_reg - n0_reg;
                s1_next = itot_reg - s0_reg;
                if (n0_reg == '0 || ptot_reg == n0_reg) begin
                    state_next = ST_NEXT;
                end else begin
                    acc_next    = '0;
                    mcand_next  = PW'(s0_reg);
                    mplier_next = DW'(ptot_reg - n0_reg);
                    op_next     = OP_A;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mplier_reg != '0) begin
                    if (mplier_reg[0]) begin
                        acc_next = acc_reg + mcand_reg;
                    end
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                end else begin
                    acc_next = '0;
                    unique case (op_reg)
                        OP_A: begin
                            a_next      = DW'(acc_reg);
                            mcand_next  = PW'(s1_reg);
                            mplier_next = DW'(n0_reg);
                            op_next     = OP_B;
                        end
                        OP_B: begin
                            d_next      = (a_reg >= DW'(acc_reg)) ? a_reg - DW'(acc_reg)
                                                                   : DW'(acc_reg) - a_reg;
                            mcand_next  = PW'(n0_reg);
                            mplier_next = DW'(n1_reg);
                            op_next     = OP_P;
                        end
                        OP_P: begin
                            p_next = QW'(acc_reg);
                            if (!have_reg) begin
                                have_next   = 1'b1;
                                best_d_next = d_reg;
                                best_p_next = QW'(acc_reg);
                                best_t_next = 8'(t_reg);
                                state_next  = ST_NEXT;
                            end else begin
                                mcand_next  = ext_p(d_reg);
                                mplier_next = d_reg;
                                op_next     = OP_D2;
                            end
                        end
                        OP_D2: begin
                            mcand_next  = acc_reg;
                            mplier_next = DW'(best_p_reg);
                            op_next     = OP_L;
                        end
                        OP_L: begin
                            lhs_next    = acc_reg;
                            mcand_next  = ext_p(best_d_reg);
                            mplier_next = best_d_reg;
                            op_next     = OP_E2;
                        end
                        OP_E2: begin
                            mcand_next  = acc_reg;
                            mplier_next = DW'(p_reg);
                            op_next     = OP_R;
                        end
                        OP_R: begin
                            // later split must be strictly better
                            if (lhs_reg > acc_reg) begin
                                best_d_next = d_reg;
                                best_p_next = p_reg;
                                best_t_next = 8'(t_reg);
                            end
                            state_next = ST_NEXT;
                        end
                        default: state_next = ST_NEXT;
                    endcase
                end
            end
            ST_NEXT: begin
                if (t_reg == BW'(BINS - 1)) begin
                    state_next = ST_FIN;
                end else begin
                    t_next     = t_reg + BW'(1);
                    state_next = ST_SR_RD;
                end
            end
            ST_FIN: begin
                hvalid_next = '0;
                ptot_next   = '0;
                itot_next   = '0;
                chosen_next = best_t_reg;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_REPORT;
                    m_thr_next   = chosen_reg;
                    m_mask_next  = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_A;
            hvalid_reg  <= '0;
            ptot_reg    <= '0;
            itot_reg    <= '0;
            chosen_reg  <= '0;
            m_valid_reg <= 1'b0;
            t_reg       <= '0;
            have_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            hvalid_reg  <= hvalid_next;
            ptot_reg    <= ptot_next;
            itot_reg    <= itot_next;
            chosen_reg  <= chosen_next;
            m_valid_reg <= m_valid_next;
            t_reg       <= t_next;
            have_reg    <= have_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        bin_reg    <= bin_next;
        count_reg  <= count_next;
        last_reg   <= last_next;
        m_thr_reg  <= m_thr_next;
        m_mask_reg <= m_mask_next;
        m_kind_reg <= m_kind_next;
        n0_reg     <= n0_next;
        n1_reg     <= n1_next;
        s0_reg     <= s0_next;
        s1_reg     <= s1_next;
        a_reg      <= a_next;
        d_reg      <= d_next;
        best_d_reg <= best_d_next;
        p_reg      <= p_next;
        best_p_reg <= best_p_next;
        best_t_reg <= best_t_next;
        lhs_reg    <= lhs_next;
        mcand_reg  <= mcand_next;
        acc_reg    <= acc_next;
        mplier_reg <= mplier_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {7'b0, m_mask_reg, m_thr_reg};

    // checks
    `OTB_ASSERT_IMP(a_ready_idle, aclk, aresetn, s_tready, state_reg == ST_IDLE)
    `OTB_ASSERT_NXT(a_fin_report, aclk, aresetn, state_reg == ST_FIN,
                    state_reg == ST_OUT && ptot_reg == '0 && hvalid_reg == '0)
    `OTB_ASSERT_IMP(a_report_nomask, aclk, aresetn,
                    m_valid_reg && m_kind_reg == KIND_REPORT, !m_mask_reg)
    `OTB_ASSERT_IMP(a_count_cap, aclk, aresetn, 1'b1, ptot_reg <= CW'(MAX_PIXELS))

endmodule
